@@ src/olpd_pkg.sv @@
// Shared definitions for the ordered list with positional delete.
// Holds field widths, operation and status codes and the control word
// passed from the decoder to the cell row. Depends on nothing.
package olpd_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WORD_W    = 32;
	localparam int KIND_W    = 3;
	localparam int POS_W     = 7;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 7;

	localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RM_FIRST = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RM_LAST  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RM_POS   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RM_MID   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic                load_tail;
		logic                close_gap;
		logic [STATUS_W-1:0] status;
	} ctrl_t;

endpackage

@@ src/olpd_cell.sv @@
// One storage cell of the list row: holds a single word.
// Loads the appended word or its right neighbour's word when a gap closes.
// Depends on olpd_pkg.
module olpd_cell #(
	parameter int DEPTH    = olpd_pkg::DEPTH_DEF,
	parameter int CELL_IDX = 0
) (
	input  logic                             clk,
	input  olpd_pkg::ctrl_t                  ctl,
	input  logic [$clog2(DEPTH)-1:0]         rm_idx,
	input  logic [$clog2(DEPTH+1)-1:0]       cnt,
	input  logic signed [olpd_pkg::WORD_W-1:0] app_value,
	input  logic signed [olpd_pkg::WORD_W-1:0] next_value,
	output logic signed [olpd_pkg::WORD_W-1:0] value_q,
	output logic signed [olpd_pkg::WORD_W-1:0] tap
);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] MY_POS  = CW'(CELL_IDX);
	localparam logic [CW-1:0] MY_NEXT = CW'(CELL_IDX + 1);
	localparam logic [IW-1:0] MY_IDX  = IW'(CELL_IDX);

	logic take_app, take_next;

	assign take_app  = ctl.load_tail && (cnt == MY_POS);
	// Cells from the removed place up to the one before the tail shift down.
	assign take_next = ctl.close_gap && (MY_IDX >= rm_idx) && (MY_NEXT < cnt);

	always_ff @(posedge clk) begin
		if (take_app) begin
			value_q <= app_value;
		end else if (take_next) begin
			value_q <= next_value;
		end
	end

	assign tap = (MY_IDX == rm_idx) ? value_q : '0;

endmodule

@@ src/olpd_ctrl.sv @@
// Operation decoder: turns one command word and the current count into
// the control word for the cell row, the index to remove and the new count.
// Depends on olpd_pkg.
module olpd_ctrl #(
	parameter int DEPTH = olpd_pkg::DEPTH_DEF
) (
	input  logic                               start,
	input  logic [olpd_pkg::KIND_W-1:0]        kind,
	input  logic [olpd_pkg::POS_W-1:0]         position,
	input  logic [$clog2(DEPTH+1)-1:0]         cnt,
	output olpd_pkg::ctrl_t                    ctl,
	output logic [$clog2(DEPTH)-1:0]           rm_idx,
	output logic [$clog2(DEPTH+1)-1:0]         cnt_d
);
	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > olpd_pkg::POS_W) ? CW : olpd_pkg::POS_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [CMPW-1:0] pos_ext, cnt_ext, idx_ext;
	logic            empty, full;

	assign pos_ext = CMPW'(position);
	assign cnt_ext = CMPW'(cnt);
	assign empty   = (cnt == '0);
	assign full    = (cnt == FULL_CNT);

	always_comb begin
		ctl     = '{load_tail: 1'b0, close_gap: 1'b0, status: olpd_pkg::ST_OK};
		idx_ext = '0;
		unique case (kind)
			olpd_pkg::KIND_APPEND: begin
				if (full) begin
					ctl.status = olpd_pkg::ST_FULL;
				end else begin
					ctl.load_tail = start;
				end
			end
			olpd_pkg::KIND_RM_FIRST: begin
				idx_ext = '0;
			end
			olpd_pkg::KIND_RM_LAST: begin
				idx_ext = cnt_ext - CMPW'(1);
			end
			olpd_pkg::KIND_RM_POS: begin
				idx_ext = pos_ext - CMPW'(1);
			end
			olpd_pkg::KIND_RM_MID: begin
				idx_ext = cnt_ext >> 1;
			end
			default: begin
				idx_ext = '0;
			end
		endcase
		if (kind == olpd_pkg::KIND_RM_FIRST || kind == olpd_pkg::KIND_RM_LAST ||
		    kind == olpd_pkg::KIND_RM_POS || kind == olpd_pkg::KIND_RM_MID) begin
			if (empty) begin
				ctl.status = olpd_pkg::ST_EMPTY;
			end else if (kind == olpd_pkg::KIND_RM_POS &&
			             (pos_ext == '0 || pos_ext > cnt_ext)) begin
				ctl.status = olpd_pkg::ST_MISSING;
			end else begin
				ctl.close_gap = start;
			end
		end
	end

	assign rm_idx = IW'(idx_ext);

	always_comb begin
		if (ctl.load_tail) begin
			cnt_d = cnt + CW'(1);
		end else if (ctl.close_gap) begin
			cnt_d = cnt - CW'(1);
		end else begin
			cnt_d = cnt;
		end
	end

endmodule

@@ src/ordered_list_with_positional_delete.sv @@
// Ordered list with positional delete: a row of DEPTH word cells.
// Result: the result word appears on the result ports in the cycle after the
// command is taken, marked by done for exactly one cycle.
// Throughput: one command per cycle; busy stays low, since the whole cell row
// shifts or loads at the edge that takes the command.
// Reset: arst_n clears the entry count and the result strobe; cell contents stay
// undefined and are never read before they are written.
module ordered_list_with_positional_delete #(
	parameter int DEPTH = olpd_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [olpd_pkg::KIND_W-1:0]          kind,
	input  logic signed [olpd_pkg::WORD_W-1:0]   value,
	input  logic [olpd_pkg::POS_W-1:0]           position,
	output logic                                 done,
	output logic [olpd_pkg::STATUS_W-1:0]        status,
	output logic signed [olpd_pkg::WORD_W-1:0]   removed_value,
	output logic [olpd_pkg::COUNT_W-1:0]         entry_count
);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Live entry count; cells below it hold the list in order.
	logic [CW-1:0] count_q, count_d;
	logic          done_q;
	logic [olpd_pkg::STATUS_W-1:0]      status_q;
	logic signed [olpd_pkg::WORD_W-1:0] removed_q;

	olpd_pkg::ctrl_t  ctl;
	logic [IW-1:0]    rm_idx;
	logic             accept;

	logic signed [olpd_pkg::WORD_W-1:0] cell_value [DEPTH];
	logic signed [olpd_pkg::WORD_W-1:0] cell_tap   [DEPTH];
	logic signed [olpd_pkg::WORD_W-1:0] tap_or;

	// Every command finishes in the cycle it is taken, so the block is never busy.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	olpd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.start    (accept),
		.kind     (kind),
		.position (position),
		.cnt      (count_q),
		.ctl      (ctl),
		.rm_idx   (rm_idx),
		.cnt_d    (count_d)
	);

	// The cell row. Each cell sees its right neighbour's word, so a removal
	// closes the gap with all shifting cells loading together; the last cell has no
	// neighbour and is never asked to shift.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [olpd_pkg::WORD_W-1:0] nb;
		if (i == DEPTH - 1) begin : g_last
			assign nb = '0;
		end else begin : g_mid
			assign nb = cell_value[i+1];
		end
		olpd_cell #(.DEPTH(DEPTH), .CELL_IDX(i)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.rm_idx     (rm_idx),
			.cnt        (count_q),
			.app_value  (value),
			.next_value (nb),
			.value_q    (cell_value[i]),
			.tap        (cell_tap[i])
		);
	end

	// Only the cell at the removal index drives a non-zero tap, so an OR
	// across the row picks out the word that leaves the list.
	always_comb begin
		tap_or = '0;
		for (int j = 0; j < DEPTH; j++) begin
			tap_or = tap_or | cell_tap[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// Result payload; it is only looked at while done is high.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= ctl.status;
			removed_q <= ctl.close_gap ? tap_or : '0;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = olpd_pkg::COUNT_W'(count_q);

	// Each command gives exactly one result in the following cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("command gave no result");

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without a command");

	// The count never exceeds the capacity of the row.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond capacity");

	// A full report leaves a full list; an empty report an empty one.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == olpd_pkg::ST_FULL) |-> (count_q == CW'(DEPTH)))
		else $error("full reported on a list with room");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == olpd_pkg::ST_EMPTY) |-> (count_q == '0))
		else $error("empty reported on a list with entries");

	// A successful removal shrinks the list by exactly one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.close_gap |=> (count_q == $past(count_q) - CW'(1)))
		else $error("removal did not shrink the list by one");

endmodule

@@ sim/ordered_list_with_positional_delete_tb.sv @@
// Self-checking testbench for ordered_list_with_positional_delete.
// Depends on olpd_pkg for widths and codes and on the block itself; it keeps
// its own copy of the list to predict every result word.
`timescale 1ns / 100ps

module ordered_list_with_positional_delete_tb;

	localparam int LIST_DEPTH     = olpd_pkg::DEPTH_DEF;
	// Cycles without any accepted word before the run is declared hung. The
	// longest correct quiet stretch is the reset plus one sender gap.
	localparam int STALL_LIMIT    = 1000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_ITEMS   = 780;

	typedef logic [olpd_pkg::KIND_W-1:0]  kind_t;
	typedef logic [olpd_pkg::POS_W-1:0]   pos_t;
	typedef logic [olpd_pkg::COUNT_W-1:0] fill_t;

	localparam kind_t KIND_TOP = '1;
	localparam pos_t  POS_TOP  = '1;

	// Everything the block reports for one command.
	typedef struct packed {
		logic [olpd_pkg::STATUS_W-1:0]      status;
		logic signed [olpd_pkg::WORD_W-1:0] removed;
		logic [olpd_pkg::COUNT_W-1:0]       fill;
	} list_result_t;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [olpd_pkg::KIND_W-1:0]        kind;
	logic signed [olpd_pkg::WORD_W-1:0] value;
	logic [olpd_pkg::POS_W-1:0]         position;
	logic                               done;
	logic [olpd_pkg::STATUS_W-1:0]      status;
	logic signed [olpd_pkg::WORD_W-1:0] removed_value;
	logic [olpd_pkg::COUNT_W-1:0]       entry_count;

	// Shadow copy of the list contents, oldest entry at index 0.
	logic signed [olpd_pkg::WORD_W-1:0] shadow_list[$];
	// Results that the block still owes, in command order.
	list_result_t                       pending_results[$];

	int error_count = 0;
	int quiet_cycles = 0;

	// Sender pacing: words go out in bursts, with gaps between them while
	// gaps_enabled is set.
	bit gaps_enabled = 1'b1;
	int burst_left = 0;

	ordered_list_with_positional_delete #(
		.DEPTH(LIST_DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.value        (value),
		.position     (position),
		.done         (done),
		.status       (status),
		.removed_value(removed_value),
		.entry_count  (entry_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Applies one command to the shadow list and returns what the block must
	// answer. Removal kinds share the empty check; the position form also
	// rejects position zero and positions past the tail.
	function automatic list_result_t apply_list_op(input kind_t op_kind,
			input logic signed [olpd_pkg::WORD_W-1:0] op_value, input pos_t op_pos);
		list_result_t res;
		int idx;
		res.status = olpd_pkg::ST_OK;
		res.removed = '0;
		idx = -1;
		case (op_kind)
			olpd_pkg::KIND_APPEND: begin
				if (shadow_list.size() >= LIST_DEPTH)
					res.status = olpd_pkg::ST_FULL;
				else
					shadow_list.push_back(op_value);
			end
			olpd_pkg::KIND_RM_FIRST, olpd_pkg::KIND_RM_LAST, olpd_pkg::KIND_RM_POS,
			olpd_pkg::KIND_RM_MID: begin
				if (shadow_list.size() == 0) begin
					res.status = olpd_pkg::ST_EMPTY;
				end else if (op_kind == olpd_pkg::KIND_RM_FIRST) begin
					idx = 0;
				end else if (op_kind == olpd_pkg::KIND_RM_LAST) begin
					idx = shadow_list.size() - 1;
				end else if (op_kind == olpd_pkg::KIND_RM_MID) begin
					idx = shadow_list.size() / 2;
				end else if (op_pos == 0 || op_pos > shadow_list.size()) begin
					res.status = olpd_pkg::ST_MISSING;
				end else begin
					idx = int'(op_pos) - 1;
				end
				if (idx >= 0) begin
					res.removed = shadow_list[idx];
					shadow_list.delete(idx);
				end
			end
			default: ; // unused kinds leave the list alone and report ok
		endcase
		res.fill = fill_t'(shadow_list.size());
		return res;
	endfunction

	// Presents one command word and holds it until the block takes it. Start
	// is left high afterwards so that back-to-back words need no toggling; a
	// gap, when one is drawn, lowers it before the next word goes out.
	task automatic issue_word(input kind_t op_kind,
			input logic signed [olpd_pkg::WORD_W-1:0] op_value, input pos_t op_pos);
		int gap;
		if (gaps_enabled && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				gap = $urandom_range(1, 6);
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		start    <= 1'b1;
		kind     <= op_kind;
		value    <= op_value;
		position <= op_pos;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(apply_list_op(op_kind, op_value, op_pos));
	endtask

	// Picks one of the four removal kinds at random.
	function automatic kind_t random_removal();
		case ($urandom_range(0, 3))
			0: return olpd_pkg::KIND_RM_FIRST;
			1: return olpd_pkg::KIND_RM_LAST;
			2: return olpd_pkg::KIND_RM_POS;
			default: return olpd_pkg::KIND_RM_MID;
		endcase
	endfunction

	// Mostly random values, now and then one of the extremes of the word.
	function automatic logic signed [olpd_pkg::WORD_W-1:0] random_value();
		case ($urandom_range(0, 15))
			0: return {1'b1, {(olpd_pkg::WORD_W-1){1'b0}}};
			1: return {1'b0, {(olpd_pkg::WORD_W-1){1'b1}}};
			default: return $urandom;
		endcase
	endfunction

	// A removal position that is usually inside the list, otherwise anything
	// the port can carry.
	function automatic pos_t random_position();
		if (shadow_list.size() > 0 && $urandom_range(0, 9) < 8)
			return pos_t'($urandom_range(1, shadow_list.size()));
		return pos_t'($urandom_range(0, POS_TOP));
	endfunction

	// Every removal kind on an empty list, with several positions, and two of
	// the unused kinds, which must leave the list alone.
	task automatic test_empty_list();
		issue_word(olpd_pkg::KIND_RM_FIRST, 32'sd0, '0);
		issue_word(olpd_pkg::KIND_RM_LAST, 32'sd0, '0);
		issue_word(olpd_pkg::KIND_RM_POS, 32'sd0, '0);
		issue_word(olpd_pkg::KIND_RM_POS, 32'sd0, 7'd1);
		issue_word(olpd_pkg::KIND_RM_POS, 32'sd0, POS_TOP);
		issue_word(olpd_pkg::KIND_RM_MID, 32'sd0, '0);
		issue_word(olpd_pkg::KIND_RM_MID + 3'd1, random_value(), POS_TOP);
		issue_word(KIND_TOP, random_value(), '0);
	endtask

	// Short list holding the word extremes; every removal form, bad positions
	// included, is tried on it.
	task automatic test_basic_ops();
		issue_word(olpd_pkg::KIND_APPEND, {1'b1, {(olpd_pkg::WORD_W-1){1'b0}}}, '0);
		issue_word(olpd_pkg::KIND_APPEND, {1'b0, {(olpd_pkg::WORD_W-1){1'b1}}}, POS_TOP);
		issue_word(olpd_pkg::KIND_APPEND, 32'sd0, '0);
		issue_word(olpd_pkg::KIND_APPEND, -32'sd1, '0);
		issue_word(olpd_pkg::KIND_APPEND, 32'sd1, '0);
		issue_word(olpd_pkg::KIND_RM_POS, 32'sd0, '0);      // position zero is missing
		issue_word(olpd_pkg::KIND_RM_POS, 32'sd0, 7'd6);    // one past the tail
		issue_word(olpd_pkg::KIND_RM_POS, 32'sd0, POS_TOP);
		issue_word(olpd_pkg::KIND_RM_MID, 32'sd0, '0);
		issue_word(olpd_pkg::KIND_RM_POS, 32'sd0, 7'd4);    // tail by position
		issue_word(olpd_pkg::KIND_RM_POS, 32'sd0, 7'd1);    // head by position
		issue_word(olpd_pkg::KIND_RM_FIRST, 32'sd0, '0);
		issue_word(olpd_pkg::KIND_RM_LAST, 32'sd0, '0);
		issue_word(olpd_pkg::KIND_RM_MID, 32'sd0, '0);      // centre of an empty list
		issue_word(olpd_pkg::KIND_RM_LAST, 32'sd0, '0);     // list still empty
	endtask

	// Fills the list to the brim, pushes past it, removes at the highest position
	// and in the middle with refills, then drains it with random removals.
	task automatic test_fill_to_full();
		while (shadow_list.size() < LIST_DEPTH)
			issue_word(olpd_pkg::KIND_APPEND, random_value(),
				pos_t'($urandom_range(0, POS_TOP)));
		issue_word(olpd_pkg::KIND_APPEND, {1'b1, {(olpd_pkg::WORD_W-1){1'b0}}}, '0);
		issue_word(olpd_pkg::KIND_APPEND, random_value(), '0);
		issue_word(olpd_pkg::KIND_RM_POS, 32'sd0, pos_t'(LIST_DEPTH));
		issue_word(olpd_pkg::KIND_APPEND, random_value(), '0);
		issue_word(olpd_pkg::KIND_RM_MID, 32'sd0, '0);
		issue_word(olpd_pkg::KIND_APPEND, random_value(), '0);
		issue_word(olpd_pkg::KIND_APPEND, random_value(), '0);
		while (shadow_list.size() > 0)
			issue_word(random_removal(), random_value(), random_position());
	endtask

	// Long random run. The fill level is steered towards a target that moves
	// now and then, sometimes to empty or full, so that both boundaries are
	// visited from a populated list. Gaps are switched off for some stretches.
	task automatic test_random_mix(input int n_items);
		int issued;
		int target;
		int append_pct;
		issued = 0;
		target = LIST_DEPTH / 2;
		while (issued < n_items) begin
			if ($urandom_range(0, 39) == 0) begin
				case ($urandom_range(0, 3))
					0: target = 0;
					1: target = LIST_DEPTH;
					default: target = $urandom_range(0, LIST_DEPTH);
				endcase
			end
			if (issued % 120 == 0)
				gaps_enabled = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 4) begin
				// Unused kind: the block ignores it, so it is not counted.
				issue_word(kind_t'($urandom_range(olpd_pkg::KIND_RM_MID + 1, KIND_TOP)),
					$urandom, pos_t'($urandom_range(0, POS_TOP)));
			end else begin
				append_pct = (shadow_list.size() < target) ? 75 : 25;
				if ($urandom_range(0, 99) < append_pct)
					issue_word(olpd_pkg::KIND_APPEND, random_value(),
						pos_t'($urandom_range(0, POS_TOP)));
				else
					issue_word(random_removal(), $urandom, random_position());
				issued++;
			end
		end
	endtask

	// Every result word is compared with the oldest outstanding prediction.
	// Outputs are sampled at the edge that ends the strobe cycle.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_error("result word with no command outstanding");
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_error($sformatf("status %0d, expected %0d", status, want.status));
				if (removed_value !== want.removed)
					report_error($sformatf("removed_value %0d, expected %0d",
						removed_value, want.removed));
				if (entry_count !== want.fill)
					report_error($sformatf("entry_count %0d, expected %0d",
						entry_count, want.fill));
			end
		end
	end

	// Watchdog: a run that stops moving words in either direction is hung.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		kind     <= '0;
		value    <= '0;
		position <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_basic_ops();
		test_fill_to_full();
		test_random_mix(RANDOM_ITEMS);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
